// File: design/dxt_pkg.sv
// Shared types, constants and arithmetic helpers for the DXT block decoder.
package dxt_pkg;

  // Largest image edge honoured by the inside test.
  localparam int unsigned MaxEdge = 16384;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgFormatMode  = 2'd0,
    CfgImageWidth  = 2'd1,
    CfgImageHeight = 2'd2
  } cfg_reg_e;

  // Format codes; the unused code decodes as DXT1.
  typedef enum logic [1:0] {
    FmtDxt1 = 2'd0,
    FmtDxt3 = 2'd1,
    FmtDxt5 = 2'd2
  } fmt_e;

  // Live configuration.
  typedef struct packed {
    logic [1:0]  mode;
    logic [14:0] width;
    logic [14:0] height;
  } dxt_cfg_t;

  // One decoded block as queued between front and back.
  // Palette entries hold red [23:16], green [15:8], blue [7:0].
  typedef struct packed {
    logic [13:0]      bx;
    logic [13:0]      by;
    logic [31:0]      cidx;
    logic [3:0][23:0] pal;
    logic [15:0][7:0] alpha;
  } dxt_entry_t;

  // 5-bit channel to 8 bits, v*255/31 truncated: one reciprocal multiply.
  function automatic logic [7:0] exp5(logic [4:0] v);
    logic [28:0] p;
    p = 29'(v) * 29'(8625630);
    return p[27:20];
  endfunction

  // 6-bit channel to 8 bits, v*255/63 truncated.
  function automatic logic [7:0] exp6(logic [5:0] v);
    logic [28:0] p;
    p = 29'(v) * 29'(4244475);
    return p[27:20];
  endfunction

  // s/3 for s up to 765.
  function automatic logic [7:0] div3(logic [9:0] s);
    logic [19:0] p;
    p = 20'(s) * 20'(683);
    return p[18:11];
  endfunction

  // n/7 for n up to 1785.
  function automatic logic [7:0] div7(logic [10:0] n);
    logic [24:0] p;
    p = 25'(n) * 25'(9363);
    return p[23:16];
  endfunction

  // n/5 for n up to 1275.
  function automatic logic [7:0] div5(logic [10:0] n);
    logic [24:0] p;
    p = 25'(n) * 25'(13108);
    return p[23:16];
  endfunction

endpackage

// File: design/dxt_intf.sv
// Channel interfaces: compressed block in, texel out, configuration write.
interface dxt_blk_if;
  logic        valid;
  logic        ready;
  logic [13:0] block_x;
  logic [13:0] block_y;
  logic [63:0] color_block;
  logic [63:0] alpha_block;

  modport source (output valid, block_x, block_y, color_block, alpha_block, input ready);
  modport sink   (input valid, block_x, block_y, color_block, alpha_block, output ready);
endinterface

interface dxt_tex_if;
  logic        valid;
  logic        ready;
  logic [14:0] texel_x;
  logic [14:0] texel_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        inside_res;
  logic        last_texel;

  modport source (output valid, texel_x, texel_y, red, green, blue, alpha, inside_res,
                  last_texel, input ready);
  modport sink   (input valid, texel_x, texel_y, red, green, blue, alpha, inside_res,
                  last_texel, output ready);
endinterface

interface dxt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/dxt_block_decoder.sv
// Top level of the DXT1/DXT3/DXT5 block decoder.
// Usage:
//   blk_i takes one compressed 4x4 block word (position, colour and alpha
//   halves); tex_o gives sixteen RGBA texel words per block in row order,
//   each with its coordinates, an inside-image flag and a last mark on the
//   sixteenth. cfg_i writes format mode, image width and image height; write
//   it only while no block is in flight.
// Path: a block passes the two front stages, the queue and the output
//   register before its first texel is valid; the other texels follow in
//   order while the receiver keeps ready high.
// Throughput: one texel per cycle while tex_o.ready is high and a decoded
//   block waits, set by the back end's texel counter driving the single
//   output register. The front accepts the next block while the back end is
//   still emitting, and a two-entry queue holds decoded blocks between them.
// Reset: all valids clear, format becomes DXT1, width and height become one.
// Stall: when tex_o.ready is low the output word holds; the queue fills and
//   then blk_i.ready drops until room opens.
module dxt_block_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  dxt_cfg_if.sink   cfg_i,
  dxt_blk_if.sink   blk_i,
  dxt_tex_if.source tex_o
);
  import dxt_pkg::*;

  dxt_cfg_t   cfg_q;
  dxt_entry_t push_data, pop_data;
  logic       push_valid, push_ready, pop_valid, pop;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= FmtDxt1;
      cfg_q.width  <= 15'd1;
      cfg_q.height <= 15'd1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgFormatMode:  cfg_q.mode   <= cfg_i.data[1:0];
        CfgImageWidth:  cfg_q.width  <= cfg_i.data;
        CfgImageHeight: cfg_q.height <= cfg_i.data;
        default: ;
      endcase
    end
  end

  dxt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .blk_i        (blk_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  dxt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  dxt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .blk_valid_i (pop_valid),
    .blk_i       (pop_data),
    .pop_o       (pop),
    .tex_o       (tex_o)
  );

endmodule

// File: design/dxt_front.sv
// Front end: accepts blocks and builds palette and per-texel alpha in two stages.
module dxt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  dxt_blk_if.sink             blk_i,
  input  dxt_pkg::dxt_cfg_t   cfg_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output dxt_pkg::dxt_entry_t push_data_o
);
  import dxt_pkg::*;

  typedef struct packed {
    logic [13:0] bx;
    logic [13:0] by;
    logic [63:0] cblk;
    logic [63:0] ablk;
    logic        dxt3;
    logic        dxt5;
  } s1_t;

  typedef struct packed {
    logic [13:0]      bx;
    logic [13:0]      by;
    logic [31:0]      cidx;
    logic [63:0]      ablk;
    logic             dxt3;
    logic             dxt5;
    logic             four;
    logic [23:0]      e0;
    logic [23:0]      e1;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic             seven;
    logic [5:0][10:0] num;
  } s2_t;

  s1_t  s1_q;
  s2_t  s2_q, s2_d;
  logic s1_valid_q, s2_valid_q;
  logic s1_move, s2_ready;

  // Handshake between the stages
  assign s2_ready     = ~s2_valid_q | push_ready_i;
  assign s1_move      = s1_valid_q & s2_ready;
  assign blk_i.ready  = ~s1_valid_q | s2_ready;
  assign push_valid_o = s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (blk_i.ready) s1_valid_q <= blk_i.valid;
      if (s2_ready)    s2_valid_q <= s1_move;
    end
  end

  // Stage 1 and stage 2 capture
  always_ff @(posedge clk_i) begin
    if (blk_i.valid && blk_i.ready) begin
      s1_q.bx   <= blk_i.block_x;
      s1_q.by   <= blk_i.block_y;
      s1_q.cblk <= blk_i.color_block;
      s1_q.ablk <= blk_i.alpha_block;
      s1_q.dxt3 <= (cfg_i.mode == FmtDxt3);
      s1_q.dxt5 <= (cfg_i.mode == FmtDxt5);
    end
    if (s1_move) s2_q <= s2_d;
  end

  // Stage 1: endpoint expansion, mode decision, alpha ramp numerators
  always_comb begin
    logic [15:0] c0, c1;
    logic [7:0]  a0, a1;
    logic [10:0] n7, n5;
    c0 = s1_q.cblk[15:0];
    c1 = s1_q.cblk[31:16];
    a0 = s1_q.ablk[7:0];
    a1 = s1_q.ablk[15:8];
    s2_d.bx    = s1_q.bx;
    s2_d.by    = s1_q.by;
    s2_d.cidx  = s1_q.cblk[63:32];
    s2_d.ablk  = s1_q.ablk;
    s2_d.dxt3  = s1_q.dxt3;
    s2_d.dxt5  = s1_q.dxt5;
    s2_d.four  = (c0 > c1) | s1_q.dxt3 | s1_q.dxt5;
    s2_d.e0    = {exp5(c0[15:11]), exp6(c0[10:5]), exp5(c0[4:0])};
    s2_d.e1    = {exp5(c1[15:11]), exp6(c1[10:5]), exp5(c1[4:0])};
    s2_d.a0    = a0;
    s2_d.a1    = a1;
    s2_d.seven = (a0 > a1);
    for (int i = 1; i <= 6; i++) begin
      n7 = 11'(7 - i) * 11'(a0) + 11'(i) * 11'(a1);
      n5 = (i <= 4) ? 11'(5 - i) * 11'(a0) + 11'(i) * 11'(a1) : 11'd0;
      s2_d.num[i-1] = s2_d.seven ? n7 : n5;
    end
  end

  // Stage 2: palette blends, alpha ramp, per-texel alpha
  always_comb begin
    logic [7:0]      ca, cb;
    logic [7:0]      ramp [8];
    logic [1:0]      ci;
    logic [3:0]      nib;
    logic [2:0]      ai;
    push_data_o.bx   = s2_q.bx;
    push_data_o.by   = s2_q.by;
    push_data_o.cidx = s2_q.cidx;
    push_data_o.pal[0] = s2_q.e0;
    push_data_o.pal[1] = s2_q.e1;
    for (int ch = 0; ch < 3; ch++) begin
      ca = s2_q.e0[8*ch +: 8];
      cb = s2_q.e1[8*ch +: 8];
      if (s2_q.four) begin
        push_data_o.pal[2][8*ch +: 8] = div3({1'b0, ca, 1'b0} + 10'(cb));
        push_data_o.pal[3][8*ch +: 8] = div3(10'(ca) + {1'b0, cb, 1'b0});
      end else begin
        push_data_o.pal[2][8*ch +: 8] = 8'((9'(ca) + 9'(cb)) >> 1);
        push_data_o.pal[3][8*ch +: 8] = 8'd0;
      end
    end
    // Alpha ramp
    ramp[0] = s2_q.a0;
    ramp[1] = s2_q.a1;
    for (int i = 0; i < 6; i++) begin
      if (s2_q.seven)  ramp[i+2] = div7(s2_q.num[i]);
      else if (i < 4)  ramp[i+2] = div5(s2_q.num[i]);
      else if (i == 4) ramp[i+2] = 8'd0;
      else             ramp[i+2] = 8'd255;
    end
    // Per-texel alpha
    for (int t = 0; t < 16; t++) begin
      ci  = s2_q.cidx[2*t +: 2];
      nib = s2_q.ablk[4*t +: 4];
      ai  = s2_q.ablk[16 + 3*t +: 3];
      if (s2_q.dxt3)      push_data_o.alpha[t] = {nib, nib};
      else if (s2_q.dxt5) push_data_o.alpha[t] = ramp[ai];
      else if (!s2_q.four && ci == 2'd3) push_data_o.alpha[t] = 8'd0;
      else                push_data_o.alpha[t] = 8'd255;
    end
  end

endmodule

// File: design/dxt_queue.sv
// Two-entry queue of decoded blocks between front and back.
module dxt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  dxt_pkg::dxt_entry_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_i,
  output dxt_pkg::dxt_entry_t pop_data_o
);
  import dxt_pkg::*;

  dxt_entry_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_i & pop_valid_o;
  assign pop_data_o   = mem_q[rptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

// File: design/dxt_back.sv
// Back end: walks the sixteen texels of the head block into the output register.
module dxt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dxt_pkg::dxt_cfg_t   cfg_i,
  input  logic                blk_valid_i,
  input  dxt_pkg::dxt_entry_t blk_i,
  output logic                pop_o,
  dxt_tex_if.source           tex_o
);
  import dxt_pkg::*;

  logic [3:0]  k_q;
  logic        out_valid_q;
  logic        load;
  logic [1:0]  ci;
  logic [14:0] tx, ty;
  logic [16:0] wlim, hlim;
  logic [23:0] rgb;

  logic [14:0] tx_q, ty_q;
  logic [23:0] rgb_q;
  logic [7:0]  alpha_q;
  logic        inside_q, last_q;

  assign load  = blk_valid_i & (~out_valid_q | tex_o.ready);
  assign pop_o = load & (k_q == 4'd15);

  // Texel position, colour and inside test
  always_comb begin
    ci   = blk_i.cidx[2*k_q +: 2];
    rgb  = blk_i.pal[ci];
    tx   = {1'b0, blk_i.bx} + 15'(k_q[1:0]);
    ty   = {1'b0, blk_i.by} + 15'(k_q[3:2]);
    wlim = ({2'b0, cfg_i.width} > 17'(MaxEdge)) ? 17'(MaxEdge) : {2'b0, cfg_i.width};
    hlim = ({2'b0, cfg_i.height} > 17'(MaxEdge)) ? 17'(MaxEdge) : {2'b0, cfg_i.height};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) k_q <= k_q + 4'd1;
      if (~out_valid_q | tex_o.ready) out_valid_q <= blk_valid_i;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      tx_q     <= tx;
      ty_q     <= ty;
      rgb_q    <= rgb;
      alpha_q  <= blk_i.alpha[k_q];
      inside_q <= ({2'b0, tx} < wlim) && ({2'b0, ty} < hlim);
      last_q   <= (k_q == 4'd15);
    end
  end

  assign tex_o.valid      = out_valid_q;
  assign tex_o.texel_x    = tx_q;
  assign tex_o.texel_y    = ty_q;
  assign tex_o.red        = rgb_q[23:16];
  assign tex_o.green      = rgb_q[15:8];
  assign tex_o.blue       = rgb_q[7:0];
  assign tex_o.alpha      = alpha_q;
  assign tex_o.inside_res = inside_q;
  assign tex_o.last_texel = last_q;

endmodule
